// ===== rtl/glwt_pkg.sv =====
// ----------------------------------------------------------------------------
// Group acknowledgement low-water tracker package
// Shared constants, types and a helper function for the tracker and its table.
// ----------------------------------------------------------------------------
package glwt_pkg;

  localparam int MAX_MEMBERS = 16;
  localparam int IDX_W       = $clog2(MAX_MEMBERS);
  localparam int CNT_W       = $clog2(MAX_MEMBERS + 1);
  localparam int MEMBER_W    = 4;
  localparam int SEQ_W       = 32;
  localparam int THR_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_IDX_W-1:0] REG_MEMBER_COUNT  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LAG_THRESHOLD = CFG_IDX_W'(1);

  localparam logic [CNT_W-1:0] COUNT_RESET  = CNT_W'(16);
  localparam logic [THR_W-1:0] THRESH_RESET = THR_W'(20);
  localparam logic [SEQ_W-1:0] SEQ_TOP      = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SCAN,
    ST_DONE
  } glwt_state_t;

  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [SEQ_W-1:0] wr_data;
    logic [IDX_W-1:0] rd_addr;
  } glwt_tbl_req_t;

  function automatic logic [SEQ_W-1:0] sat_inc(input logic [SEQ_W-1:0] v);
    sat_inc = (v == SEQ_TOP) ? SEQ_TOP : v + SEQ_W'(1);
  endfunction

endpackage

// ===== rtl/glwt_table.sv =====
// ----------------------------------------------------------------------------
// Acknowledgement table
// Per-member next-unacknowledged store with one write and one registered read
// port. Entries that were never written read as zero.
// ----------------------------------------------------------------------------
module glwt_table import glwt_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  glwt_tbl_req_t    req,
  output logic [SEQ_W-1:0] rd_data
);

  logic [SEQ_W-1:0]       mem [MAX_MEMBERS];
  logic [MAX_MEMBERS-1:0] valid_r;
  logic [SEQ_W-1:0]       rd_data_r;
  logic                   rd_valid_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    rd_data_r <= mem[req.rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        valid_r[req.wr_addr] <= 1'b1;
      end
      rd_valid_r <= valid_r[req.rd_addr];
    end
  end

  assign rd_data = rd_valid_r ? rd_data_r : '0;

endmodule

// ===== rtl/group_ack_low_water_tracker.sv =====
// ----------------------------------------------------------------------------
// Group acknowledgement low-water tracker
// Tracks member acknowledgements and reports the group low-water mark.
// ----------------------------------------------------------------------------
// Each request passes through the lookup and result states when the mark is not
// recomputed, and through a scan of the member table as well when it is; the
// minimum walks the table one entry per cycle through its single read port. The block takes no
// new request until the current one has produced its result, and a finished
// result may wait in the output register while the next request is accepted.
// Configuration writes are taken at any time and must only be issued while idle.
module group_ack_low_water_tracker import glwt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [MEMBER_W-1:0]   in_member,
  input  logic [SEQ_W-1:0]      in_ack_seq,
  input  logic [SEQ_W-1:0]      in_next_seq,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SEQ_W-1:0]      out_low_water,
  output logic                  out_retransmit,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  glwt_state_t         state_r, state_nxt;
  logic [IDX_W-1:0]    member_r;
  logic [SEQ_W-1:0]    ack_r;
  logic [SEQ_W-1:0]    next_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [SEQ_W-1:0]    m_r, m_nxt;
  logic [SEQ_W-1:0]    low_mark_r, low_mark_nxt;
  logic [CNT_W-1:0]    member_count_r;
  logic [THR_W-1:0]    lag_threshold_r;
  logic                out_valid_r, out_valid_nxt;
  logic [SEQ_W-1:0]    out_low_water_r;
  logic                out_retransmit_r;
  logic                load_out;
  logic                resend;
  logic [CNT_W-1:0]    cnt_eff;
  logic [SEQ_W-1:0]    rd_data;
  logic [SEQ_W-1:0]    stored;
  logic [SEQ_W-1:0]    m_cmp;
  glwt_tbl_req_t       tbl_req;

  glwt_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (tbl_req),
    .rd_data (rd_data)
  );

  always_comb begin
    if (member_count_r == '0) begin
      cnt_eff = CNT_W'(1);
    end else if (member_count_r > CNT_W'(MAX_MEMBERS)) begin
      cnt_eff = CNT_W'(MAX_MEMBERS);
    end else begin
      cnt_eff = member_count_r;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      member_count_r  <= COUNT_RESET;
      lag_threshold_r <= THRESH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MEMBER_COUNT:  member_count_r  <= cfg_wdata[CNT_W-1:0];
        REG_LAG_THRESHOLD: lag_threshold_r <= cfg_wdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  assign stored = (member_r == '0) ? next_r - SEQ_W'(1) : rd_data;
  assign m_cmp  = ((idx_r != member_r) && (rd_data < m_r)) ? rd_data : m_r;
  assign resend = (({1'b0, ack_r} + (SEQ_W+1)'(1)) >= {1'b0, low_mark_r}) &&
                  ({1'b0, next_r} > ({1'b0, ack_r} + (SEQ_W+1)'(lag_threshold_r)));

  always_comb begin
    state_nxt        = state_r;
    idx_nxt          = idx_r;
    m_nxt            = m_r;
    low_mark_nxt     = low_mark_r;
    load_out         = 1'b0;
    tbl_req.wr_en    = 1'b0;
    tbl_req.wr_addr  = member_r;
    tbl_req.wr_data  = sat_inc(ack_r);
    tbl_req.rd_addr  = in_member[IDX_W-1:0];
    out_valid_nxt    = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        tbl_req.rd_addr = IDX_W'(1);
        state_nxt       = ST_DONE;
        if (({1'b0, member_r} < cnt_r) && (ack_r >= stored)) begin
          tbl_req.wr_en = 1'b1;
          if (low_mark_r <= ack_r) begin
            m_nxt = sat_inc(ack_r);
            if (cnt_r > CNT_W'(1)) begin
              idx_nxt   = IDX_W'(1);
              state_nxt = ST_SCAN;
            end else begin
              low_mark_nxt = sat_inc(ack_r);
            end
          end
        end
      end
      ST_SCAN: begin
        m_nxt           = m_cmp;
        tbl_req.rd_addr = idx_r + IDX_W'(1);
        if (({1'b0, idx_r} + CNT_W'(1)) < cnt_r) begin
          idx_nxt = idx_r + IDX_W'(1);
        end else begin
          low_mark_nxt = m_cmp;
          state_nxt    = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      low_mark_r  <= '0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      low_mark_r  <= low_mark_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m_r <= m_nxt;
    if (in_valid && in_ready) begin
      member_r <= in_member[IDX_W-1:0];
      ack_r    <= in_ack_seq;
      next_r   <= in_next_seq;
      cnt_r    <= cnt_eff;
    end
    if (load_out) begin
      out_low_water_r  <= low_mark_r;
      out_retransmit_r <= resend;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_low_water  = out_low_water_r;
  assign out_retransmit = out_retransmit_r;

endmodule

// ===== rtl/glwt_checker.sv =====
// ----------------------------------------------------------------------------
// Low-water tracker checker
// Port-level assertions for the tracker, attached by a bind statement.
// ----------------------------------------------------------------------------
module glwt_checker import glwt_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [SEQ_W-1:0] out_low_water,
  input logic             out_retransmit
);

  // A request keeps the block busy for at least the lookup and result cycles.
  a_busy_after_request: assert property (@(posedge clk)
    (rst_n && in_valid && in_ready) |=> !in_ready)
    else $error("tracker took a request while still working on the previous one");

  a_busy_two_cycles: assert property (@(posedge clk)
    (rst_n && in_valid && in_ready) |=> ##1 (!in_ready || !rst_n || !$past(rst_n)))
    else $error("tracker finished a request in fewer than three cycles");

  a_out_hold: assert property (@(posedge clk)
    (rst_n && out_valid && !out_ready) |=>
      (out_valid && $stable(out_low_water) && $stable(out_retransmit)))
    else $error("stalled result changed before it was taken");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind group_ack_low_water_tracker glwt_checker u_glwt_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_low_water  (out_low_water),
  .out_retransmit (out_retransmit)
);

// ===== dv/group_ack_low_water_tracker_test.sv =====
// ----------------------------------------------------------------------------
// Group acknowledgement low-water tracker testbench
// Streams member acknowledgements through the tracker under several register
// settings. Every accepted request is run through a local table model, and each
// returned low-water mark and retransmit flag is compared with the prediction.
// ----------------------------------------------------------------------------
module group_ack_low_water_tracker_test;
  import glwt_pkg::*;

  localparam int CHUNKS       = 9;
  localparam int CHUNK_ITEMS  = 128;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 400000;

  localparam logic [CFG_DATA_W-1:0] CHUNK_COUNT [CHUNKS] =
    '{16'd16, 16'd2, 16'd1, 16'd5, 16'd0, 16'd31, 16'd12, 16'd3, 16'd16};
  localparam logic [CFG_DATA_W-1:0] CHUNK_LAG [CHUNKS] =
    '{16'd20, 16'd0, 16'hFFFF, 16'd7, 16'd300, 16'd20, 16'd0, 16'd40, 16'd20};

  typedef struct {
    logic [MEMBER_W-1:0] member;
    logic [SEQ_W-1:0]    ack_seq;
    logic [SEQ_W-1:0]    next_seq;
  } ack_item_t;

  typedef struct {
    logic [SEQ_W-1:0] low_water;
    logic             retransmit;
  } water_t;

  logic                  clk            = 1'b0;
  logic                  rst_n          = 1'b0;
  logic                  in_valid       = 1'b0;
  logic                  in_ready;
  logic [MEMBER_W-1:0]   in_member      = '0;
  logic [SEQ_W-1:0]      in_ack_seq     = '0;
  logic [SEQ_W-1:0]      in_next_seq    = '0;
  logic                  out_valid;
  logic                  out_ready      = 1'b0;
  logic [SEQ_W-1:0]      out_low_water;
  logic                  out_retransmit;
  logic                  cfg_valid      = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index      = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata      = '0;

  logic [CNT_W-1:0] shadow_count = COUNT_RESET;
  logic [THR_W-1:0] shadow_lag   = THRESH_RESET;
  logic [SEQ_W-1:0] member_floor [MAX_MEMBERS] = '{default: '0};
  logic [SEQ_W-1:0] group_floor  = '0;

  ack_item_t pending_acks [$];
  water_t    expected_marks [$];
  ack_item_t offer;
  water_t    want;

  logic [SEQ_W-1:0] seq_cursor = 32'd1000;
  bit in_taken      = 1'b0;
  int send_idle_pct = 13;
  int recv_idle_pct = 52;
  int rx_hold_len   = 0;
  int cycle_count   = 0;
  int mismatch_count = 0;
  int requests_done = 0;
  int resend_seen   = 0;
  int settings_used = 0;

  group_ack_low_water_tracker DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_member      (in_member),
    .in_ack_seq     (in_ack_seq),
    .in_next_seq    (in_next_seq),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_low_water  (out_low_water),
    .out_retransmit (out_retransmit),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic int members_in_play();
    int live;
    live = int'(shadow_count);
    if (live < 1) live = 1;
    if (live > MAX_MEMBERS) live = MAX_MEMBERS;
    return live;
  endfunction

  // The sequencer's own entry is refreshed first, then a fresh acknowledgement
  // advances its member and may pull the group floor up to the slowest member.
  function automatic water_t track_ack(input ack_item_t a);
    logic [SEQ_W-1:0] bumped;
    logic [SEQ_W-1:0] lowest;
    int live;
    int i;
    water_t w;
    live = members_in_play();
    member_floor[0] = a.next_seq - 32'd1;
    if (int'(a.member) < live && a.ack_seq >= member_floor[a.member]) begin
      bumped = (a.ack_seq == SEQ_TOP) ? SEQ_TOP : a.ack_seq + 32'd1;
      member_floor[a.member] = bumped;
      if (group_floor <= a.ack_seq) begin
        lowest = bumped;
        for (i = 1; i < live; i++) begin
          if (member_floor[i] < lowest) lowest = member_floor[i];
        end
        group_floor = lowest;
      end
    end
    w.low_water  = group_floor;
    w.retransmit = ({1'b0, a.ack_seq} + 33'd1 >= {1'b0, group_floor}) &&
                   ({1'b0, a.next_seq} > {1'b0, a.ack_seq} + {17'd0, shadow_lag});
    return w;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("cycle %0d: %s", cycle_count, what);
  endtask

  task automatic queue_ack(input logic [MEMBER_W-1:0] m, input logic [SEQ_W-1:0] a,
                           input logic [SEQ_W-1:0] n);
    ack_item_t item;
    item.member   = m;
    item.ack_seq  = a;
    item.next_seq = n;
    pending_acks.push_back(item);
  endtask

  // Mostly an orderly stream of acknowledgements trailing a rising sequence
  // number, mixed with replayed old acknowledgements and raw random requests.
  task automatic queue_traffic(input int n);
    int live;
    int pick;
    int lag;
    logic [MEMBER_W-1:0] m;
    logic [SEQ_W-1:0] a;
    logic [SEQ_W-1:0] nx;
    live = members_in_play();
    repeat (n) begin
      pick = $urandom_range(99);
      lag  = $urandom_range(30);
      if (pick < 78) begin
        m = (pick < 72) ? MEMBER_W'($urandom_range(live - 1)) : MEMBER_W'($urandom_range(15));
        seq_cursor = seq_cursor + $urandom_range(3);
        a  = (seq_cursor > SEQ_W'(lag)) ? seq_cursor - SEQ_W'(lag) : '0;
        nx = seq_cursor + $urandom_range(1, 45);
      end else if (pick < 88) begin
        m  = MEMBER_W'($urandom_range(15));
        a  = $urandom_range(seq_cursor);
        nx = $urandom();
      end else begin
        m  = (live < MAX_MEMBERS && pick < 94) ? MEMBER_W'($urandom_range(15, live)) : '0;
        a  = (live == 1 && m == '0) ? seq_cursor + $urandom_range(5) : $urandom();
        nx = $urandom();
      end
      queue_ack(m, a, nx);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_MEMBER_COUNT) shadow_count = data[CNT_W-1:0];
    else if (idx == REG_LAG_THRESHOLD) shadow_lag = data[THR_W-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] count_word,
                           input logic [CFG_DATA_W-1:0] lag_word);
    write_reg(REG_MEMBER_COUNT, count_word);
    write_reg(REG_LAG_THRESHOLD, lag_word);
    settings_used++;
    @(posedge clk);
  endtask

  task automatic settle();
    @(posedge clk);
    while (pending_acks.size() != 0 || in_valid || expected_marks.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_acks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        offer = pending_acks.pop_front();
        in_valid    <= 1'b1;
        in_member   <= offer.member;
        in_ack_seq  <= offer.ack_seq;
        in_next_seq <= offer.next_seq;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (rx_hold_len > 0) begin
      rx_hold_len = rx_hold_len - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    ack_item_t seen;
    in_taken = 1'b0;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_marks.size() == 0) begin
          report_mismatch($sformatf("result with nothing outstanding: low_water %h",
                                    out_low_water));
        end else begin
          want = expected_marks.pop_front();
          if (out_low_water !== want.low_water)
            report_mismatch($sformatf("low_water %h, expected %h",
                                      out_low_water, want.low_water));
          if (out_retransmit !== want.retransmit)
            report_mismatch($sformatf("retransmit %b, expected %b",
                                      out_retransmit, want.retransmit));
          if (want.retransmit) resend_seen++;
        end
      end
      if (in_valid && in_ready) begin
        in_taken = 1'b1;
        seen.member   = in_member;
        seen.ack_seq  = in_ack_seq;
        seen.next_seq = in_next_seq;
        expected_marks.push_back(track_ack(seen));
        requests_done++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_marks.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int c;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: wrapped next_seq, top sequence values, stale replays.
    queue_ack(4'd0, 32'd0, 32'd0);
    queue_ack(4'd3, 32'd5, 32'd40);
    queue_ack(4'd15, 32'd0, 32'hFFFF_FFFF);
    queue_ack(4'd0, 32'hFFFF_0000, 32'hFFFF_FFFF);
    queue_ack(4'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_ack(4'd3, 32'd2, 32'd10);
    queue_ack(4'd7, 32'd0, 32'd0);
    settle();

    // Widest lag threshold, where the sums must not wrap.
    configure(16'hFFF0, 16'hFFFF);
    queue_ack(4'd0, 32'hFFFF_0001, 32'hFFFF_FFFF);
    queue_ack(4'd0, 32'hFFFF_0000, 32'hFFFF_FFFF);
    queue_ack(4'd0, 32'd0, 32'hFFFF_FFFF);
    settle();

    // A single member, set directly and through a zero count.
    configure(16'h0001, 16'h0000);
    queue_ack(4'd0, 32'hFFFF_FFFF, 32'd0);
    queue_ack(4'd1, 32'd10, 32'd50);
    queue_ack(4'd15, 32'd12, 32'd60);
    settle();
    configure(16'h0000, 16'h0000);
    queue_ack(4'd0, 32'hFFFF_FFFF, 32'd5);
    queue_ack(4'd1, 32'd3, 32'd9);
    settle();

    // An oversized count is clamped to the full table.
    configure(16'h001F, 16'h0000);
    queue_ack(4'd0, 32'hFFFF_FFFF, 32'd1);
    queue_ack(4'd15, 32'd4, 32'd100);
    settle();

    configure(16'hABC4, 16'd20);
    queue_ack(4'd2, 32'd100, 32'd130);
    queue_ack(4'd1, 32'd99, 32'd99);
    queue_ack(4'd3, 32'd200, 32'd260);
    queue_ack(4'd4, 32'd300, 32'd400);
    queue_ack(4'd9, 32'hFFFF_FFFF, 32'd0);

    for (c = 0; c < CHUNKS; c++) begin
      settle();
      if (c < 3) begin
        send_idle_pct = 13;
        recv_idle_pct = 52;
      end else if (c < 6) begin
        send_idle_pct = 52;
        recv_idle_pct = 13;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (c == CHUNKS - 1) configure(CFG_DATA_W'($urandom_range(65535)),
                                     CFG_DATA_W'($urandom_range(65535)));
      else configure(CHUNK_COUNT[c], CHUNK_LAG[c]);
      if (c == 0) begin
        queue_traffic(40);
        rx_hold_len = 300;
        queue_traffic(CHUNK_ITEMS - 40);
      end else begin
        queue_traffic(CHUNK_ITEMS);
      end
    end

    settle();
    $display("Checked %0d acknowledgement requests over %0d register settings,",
             requests_done, settings_used);
    $display("%0d of them asking for a retransmit; %0d mismatches.",
             resend_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
